[rtl/tlv_stream_parser_core_assert.svh]
// Assertion macros used by the TLV parser checker.
`ifndef TLV_STREAM_PARSER_CORE_ASSERT_SVH
`define TLV_STREAM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tsp_pkg.sv]
// Types and constants of the TLV stream parser.
`default_nettype none

package tsp_pkg;

    localparam int unsigned TSP_QUEUE_DEPTH = 2;

    localparam logic [7:0] NULL_TAG_RESET = 8'h00;
    localparam logic [7:0] TERM_TAG_RESET = 8'hfe;
    localparam logic [7:0] LONG_LENGTH_MARK = 8'hff;

    localparam logic CFG_NULL_TAG = 1'b0;
    localparam logic CFG_TERM_TAG = 1'b1;

    localparam logic [1:0] CLS_NULL  = 2'd0;
    localparam logic [1:0] CLS_TERM  = 2'd1;
    localparam logic [1:0] CLS_OTHER = 2'd2;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_TERM  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    typedef struct packed {
        logic [1:0] cls;
        logic       is_mark;
        logic       is_zero;
        logic [7:0] data;
        logic       fin;
    } byte_cls_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  record_tag;
        logic [15:0] record_length;
        logic [7:0]  value_byte;
        logic [15:0] value_offset;
        logic        record_last;
        logic        stream_done;
        logic        status;
    } result_t;

endpackage

`default_nettype wire

[rtl/tsp_channels.sv]
// Channel interfaces: input bytes, parse results and register writes.
`default_nettype none

interface tsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface tsp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  record_tag;
    logic [15:0] record_length;
    logic [7:0]  value_byte;
    logic [15:0] value_offset;
    logic        record_last;
    logic        stream_done;
    logic        status;
    modport source (output valid, output kind, output record_tag, output record_length,
                    output value_byte, output value_offset, output record_last,
                    output stream_done, output status, input ready);
    modport sink (input valid, input kind, input record_tag, input record_length,
                  input value_byte, input value_offset, input record_last,
                  input stream_done, input status, output ready);
endinterface

interface tsp_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/tsp_front.sv]
// Front end: tag code registers and classification of incoming bytes.
`default_nettype none

module tsp_front
    import tsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    tsp_byte_if.sink        byte_in,
    tsp_cfg_if.sink         cfg,
    output byte_cls_t       push_item,
    output logic            push_valid,
    input  wire logic       push_ready
);

    logic [7:0] null_code_reg, null_code_next;
    logic [7:0] term_code_reg, term_code_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        null_code_next = null_code_reg;
        term_code_next = term_code_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_NULL_TAG: null_code_next = cfg.data;
                CFG_TERM_TAG: term_code_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            null_code_reg <= NULL_TAG_RESET;
            term_code_reg <= TERM_TAG_RESET;
        end
        else
        begin
            null_code_reg <= null_code_next;
            term_code_reg <= term_code_next;
        end
    end

    // null code wins when both codes match
    always_comb
    begin
        if (byte_in.data_byte == null_code_reg)
            push_item.cls = CLS_NULL;
        else if (byte_in.data_byte == term_code_reg)
            push_item.cls = CLS_TERM;
        else
            push_item.cls = CLS_OTHER;
        push_item.is_mark = (byte_in.data_byte == LONG_LENGTH_MARK);
        push_item.is_zero = (byte_in.data_byte == 8'h00);
        push_item.data    = byte_in.data_byte;
        push_item.fin     = byte_in.final_byte;
    end

    assign push_valid    = byte_in.valid;
    assign byte_in.ready = push_ready;

endmodule

`default_nettype wire

[rtl/tsp_queue.sv]
// Short queue of classified bytes between front and back end.
`default_nettype none

module tsp_queue
    import tsp_pkg::*;
#(
    parameter int unsigned DEPTH = TSP_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire byte_cls_t push_item,
    input  wire logic      push_valid,
    output logic           push_ready,
    output byte_cls_t      pop_item,
    output logic           pop_valid,
    input  wire logic      pop_ready
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    byte_cls_t         entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

[rtl/tsp_back.sv]
// Back end: TLV parse state machine and result output register.
`default_nettype none

module tsp_back
    import tsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire byte_cls_t item,
    input  wire logic      item_valid,
    output logic           item_ready,
    tsp_result_if.source   result_out
);

    localparam logic [2:0] PH_TAG    = 3'd0;
    localparam logic [2:0] PH_LEN    = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_LEN_LO = 3'd3;
    localparam logic [2:0] PH_VALUE  = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] seen_reg, seen_next;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;
    logic        advance, emit;
    logic [15:0] len_byte;
    logic [16:0] seen_inc;
    logic        value_last;

    assign item_ready = !out_valid_reg || result_out.ready;
    assign advance    = item_valid && item_ready;
    assign len_byte   = (phase_reg == PH_LEN_LO) ? {length_reg[15:8], item.data}
                                                 : {8'h00, item.data};
    assign seen_inc   = {1'b0, seen_reg} + 17'd1;
    assign value_last = (seen_inc >= {1'b0, length_reg});

    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        emit        = 1'b0;
        res_next    = '0;
        res_next.stream_done = item.fin;
        if (advance)
        begin
            case (phase_reg)
                PH_TAG:
                begin
                    if (item.cls == CLS_NULL)
                    begin
                        emit = item.fin;
                        res_next.kind = KIND_END;
                    end
                    else if (item.cls == CLS_TERM)
                    begin
                        emit = 1'b1;
                        res_next.kind = KIND_TERM;
                        res_next.record_tag = item.data;
                        res_next.record_last = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        tag_next    = item.data;
                        length_next = '0;
                        seen_next   = '0;
                        phase_next  = PH_LEN;
                        emit = item.fin;
                        res_next.kind = KIND_END;
                        res_next.record_tag = item.data;
                        res_next.status = 1'b1;
                    end
                end
                PH_LEN, PH_LEN_LO:
                begin
                    res_next.record_tag = tag_reg;
                    if (phase_reg == PH_LEN && item.is_mark)
                    begin
                        phase_next = PH_LEN_HI;
                        emit = item.fin;
                        res_next.kind = KIND_END;
                        res_next.status = 1'b1;
                    end
                    else
                    begin
                        length_next = len_byte;
                        seen_next   = '0;
                        if (len_byte == 16'h0000)
                        begin
                            emit = 1'b1;
                            res_next.kind = KIND_EMPTY;
                            res_next.record_last = 1'b1;
                            phase_next = PH_TAG;
                        end
                        else
                        begin
                            phase_next = PH_VALUE;
                            emit = item.fin;
                            res_next.kind = KIND_END;
                            res_next.record_length = len_byte;
                            res_next.status = 1'b1;
                        end
                    end
                end
                PH_LEN_HI:
                begin
                    length_next = {item.data, 8'h00};
                    phase_next  = PH_LEN_LO;
                    emit = item.fin;
                    res_next.kind = KIND_END;
                    res_next.record_tag = tag_reg;
                    res_next.record_length = {item.data, 8'h00};
                    res_next.status = 1'b1;
                end
                PH_VALUE:
                begin
                    emit = 1'b1;
                    res_next.kind = KIND_VALUE;
                    res_next.record_tag = tag_reg;
                    res_next.record_length = length_reg;
                    res_next.value_byte = item.data;
                    res_next.value_offset = seen_reg;
                    res_next.record_last = value_last;
                    res_next.status = item.fin && !value_last;
                    seen_next = seen_inc[15:0];
                    if (value_last)
                        phase_next = PH_TAG;
                end
                default:
                begin
                    emit = item.fin;
                    res_next.kind = KIND_END;
                end
            endcase
            if (item.fin)
            begin
                phase_next  = PH_TAG;
                tag_next    = '0;
                length_next = '0;
                seen_next   = '0;
            end
        end
    end

    always_comb
    begin
        if (advance)
            out_valid_next = emit;
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            tag_reg       <= '0;
            length_reg    <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tag_reg       <= tag_next;
            length_reg    <= length_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            res_reg <= res_next;
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.kind          = res_reg.kind;
    assign result_out.record_tag    = res_reg.record_tag;
    assign result_out.record_length = res_reg.record_length;
    assign result_out.value_byte    = res_reg.value_byte;
    assign result_out.value_offset  = res_reg.value_offset;
    assign result_out.record_last   = res_reg.record_last;
    assign result_out.stream_done   = res_reg.stream_done;
    assign result_out.status        = res_reg.status;

endmodule

`default_nettype wire

[rtl/tlv_stream_parser_core.sv]
// Top level of the NFC Forum TLV stream parser.
// Usage:
//   byte_in    : one byte of the tag's TLV area per item, final_byte on the last.
//   result_out : at most one result per input byte (value byte, empty record,
//                terminator, or stream end only); stream_done marks the result
//                of the final byte, status 1 means the stream was truncated
//                and every record of that stream must be dropped.
//   cfg        : register writes (index 0 null tag code, 1 terminator code),
//                always ready; write only while the parser is idle.
// Throughput: one byte per cycle while result_out is ready, bytes that give no result included.
// Path: a result passes the byte queue and then the output register; the
//   parse stage reads the queue head and loads the output register at the next edge.
// Stall: while result_out is held off the output register keeps its item,
//   the parse stage stops and the byte queue (QUEUE_DEPTH entries) fills;
//   byte_in.ready drops only when the queue is full.
// Reset: parse state returns to expect-tag, codes to 0x00 and 0xfe,
//   queue and output register empty.
// After the final byte the parse state clears and a new stream begins.
`default_nettype none

module tlv_stream_parser_core
    import tsp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = TSP_QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    tsp_byte_if.sink     byte_in,
    tsp_result_if.source result_out,
    tsp_cfg_if.sink      cfg
);

    byte_cls_t push_item, pop_item;
    logic      push_valid, push_ready;
    logic      pop_valid, pop_ready;

    tsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .cfg        (cfg),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    tsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    tsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (pop_item),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

[rtl/tsp_checker.sv]
// Port-level checker for the TLV stream parser, bound to the top level.
`default_nettype none
`include "tlv_stream_parser_core_assert.svh"

module tsp_checker
    import tsp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic [7:0]  value_byte,
    input wire logic [15:0] value_offset,
    input wire logic        record_last,
    input wire logic        stream_done,
    input wire logic        status
);

    `TSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(value_byte) && $stable(value_offset), "result item changed while stalled")
    `TSP_ASSERT_IMPL(a_status_done, clk, rst_n, out_valid && status, stream_done, "truncated status without stream end")
    `TSP_ASSERT_IMPL(a_nonvalue_zero, clk, rst_n, out_valid && kind != KIND_VALUE, value_byte == 8'h00 && value_offset == 16'h0000, "value fields set on a non-value item")
    `TSP_ASSERT_IMPL(a_last_kind, clk, rst_n, out_valid && kind != KIND_VALUE, record_last == (kind != KIND_END), "record_last wrong for item kind")

endmodule

bind tlv_stream_parser_core tsp_checker u_tsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .kind         (result_out.kind),
    .value_byte   (result_out.value_byte),
    .value_offset (result_out.value_offset),
    .record_last  (result_out.record_last),
    .stream_done  (result_out.stream_done),
    .status       (result_out.status)
);

`default_nettype wire
